// ----- sv/line_editor_echo_macros.svh -----
// assertion macros for the line editor block
`ifndef LINE_EDITOR_ECHO_MACROS_SVH
`define LINE_EDITOR_ECHO_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LEE_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LEE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- sv/lee_pkg.sv -----
// shared types, codes and constants for the line editor block
package lee_pkg;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // control characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // configuration register indexes
    localparam logic CFG_ECHO_ENABLE   = 1'b0;
    localparam logic CFG_LINE_CAPACITY = 1'b1;

    // buffer size limit; effective capacity never exceeds 256
    localparam int MAX_LINE = 256;
    localparam logic [8:0] CAP_LIMIT = (MAX_LINE < 256) ? 9'(MAX_LINE) : 9'd256;

    localparam int MAX_RESULTS = 3;

    // one result item, last is derived when it is sent
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] line_length;
    } result_t;

    // all results caused by one input character
    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

    // configuration seen by the decoder
    typedef struct packed {
        logic       echo_enable;
        logic [8:0] line_capacity;
    } cfg_t;

endpackage

// ----- sv/lee_decode.sv -----
// per-character decode: builds the result bundle and the next line length
module lee_decode
(
    input  logic [7:0]       rx_char,
    input  logic [7:0]       length_count,
    input  lee_pkg::cfg_t    cfg,
    output lee_pkg::bundle_t bundle,
    output logic [7:0]       length_next
);

    logic       is_eol;
    logic       is_erase;
    logic [8:0] cap_eff;
    logic [8:0] len_plus;
    logic [7:0] len_minus;

    // character classes and capacity clamp
    assign is_eol    = (rx_char == lee_pkg::CHAR_CR) || (rx_char == lee_pkg::CHAR_LF);
    assign is_erase  = (rx_char == lee_pkg::CHAR_BS) || (rx_char == lee_pkg::CHAR_DEL);
    assign cap_eff   = (cfg.line_capacity < lee_pkg::CAP_LIMIT) ? cfg.line_capacity
                                                                : lee_pkg::CAP_LIMIT;
    assign len_plus  = {1'b0, length_count} + 9'd1;
    assign len_minus = length_count - 8'd1;

    // result selection
    always_comb
    begin
        bundle      = '0;
        length_next = length_count;
        if (is_eol)
        begin
            length_next = 8'd0;
            if (cfg.echo_enable)
            begin
                bundle.count                 = 2'd3;
                bundle.res[0].kind           = lee_pkg::KIND_ECHO;
                bundle.res[0].data_byte      = lee_pkg::CHAR_CR;
                bundle.res[1].kind           = lee_pkg::KIND_ECHO;
                bundle.res[1].data_byte      = lee_pkg::CHAR_LF;
                bundle.res[2].kind           = lee_pkg::KIND_DONE;
                bundle.res[2].line_length    = length_count;
            end
            else
            begin
                bundle.count                 = 2'd1;
                bundle.res[0].kind           = lee_pkg::KIND_DONE;
                bundle.res[0].line_length    = length_count;
            end
        end
        else if (is_erase)
        begin
            if (length_count != 8'd0)
            begin
                length_next = len_minus;
                if (cfg.echo_enable)
                begin
                    bundle.count              = 2'd3;
                    bundle.res[0].kind        = lee_pkg::KIND_ECHO;
                    bundle.res[0].data_byte   = lee_pkg::CHAR_BS;
                    bundle.res[0].line_length = len_minus;
                    bundle.res[1].kind        = lee_pkg::KIND_ECHO;
                    bundle.res[1].data_byte   = lee_pkg::CHAR_SPACE;
                    bundle.res[1].line_length = len_minus;
                    bundle.res[2].kind        = lee_pkg::KIND_ECHO;
                    bundle.res[2].data_byte   = lee_pkg::CHAR_BS;
                    bundle.res[2].line_length = len_minus;
                end
            end
        end
        else if (len_plus < cap_eff)
        begin
            // any other byte while there is room: store, then optional echo
            length_next               = len_plus[7:0];
            bundle.res[0].kind        = lee_pkg::KIND_STORE;
            bundle.res[0].data_byte   = rx_char;
            bundle.res[0].position    = length_count;
            bundle.res[0].line_length = len_plus[7:0];
            if (cfg.echo_enable)
            begin
                bundle.count              = 2'd2;
                bundle.res[1].kind        = lee_pkg::KIND_ECHO;
                bundle.res[1].data_byte   = rx_char;
                bundle.res[1].line_length = len_plus[7:0];
            end
            else
            begin
                bundle.count = 2'd1;
            end
        end
    end

endmodule

// ----- sv/lee_emit.sv -----
// result register: holds one bundle and sends its results one per transfer
module lee_emit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lee_pkg::bundle_t bundle,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       position,
    output logic [7:0]       line_length,
    output logic             last
);

    lee_pkg::bundle_t bundle_reg;
    logic             valid_reg;
    logic             valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    lee_pkg::result_t cur;
    logic             out_xfer;

    // current entry
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = bundle_reg.res[0];
            2'd1:    cur = bundle_reg.res[1];
            2'd2:    cur = bundle_reg.res[2];
            default: cur = '0;
        endcase
    end

    assign last        = (idx_reg == (bundle_reg.count - 2'd1));
    assign out_valid   = valid_reg;
    assign kind        = cur.kind;
    assign data_byte   = cur.data_byte;
    assign position    = cur.position;
    assign line_length = cur.line_length;
    assign out_xfer    = valid_reg && out_ready;
    assign free        = !valid_reg || (out_ready && last);

    // sequencing of entries within the bundle
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (out_xfer)
        begin
            if (last)
            begin
                valid_next = 1'b0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

// ----- sv/line_editor_echo.sv -----
// line editor with backspace handling and echo: top level
// latency: first result of a character is shown the cycle after its input transfer
// throughput: a character with n results (n = 1..3) holds the output until all n have transferred;
//   a character with no result loads nothing; the next input transfers with the last result
// rate is set by the single result register sending one entry per transfer
// reset: length 0, echo on, capacity 256, no result pending
module line_editor_echo
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic [7:0] rx_char,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] position,
    output logic [7:0] line_length,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready
);

`include "line_editor_echo_macros.svh"

    logic             echo_enable_reg;
    logic [8:0]       line_capacity_reg;
    logic [7:0]       length_count_reg;
    logic [7:0]       length_next;
    lee_pkg::cfg_t    cfg;
    lee_pkg::bundle_t bundle;
    logic             in_xfer;
    logic             load;
    logic             free;

    assign cfg.echo_enable   = echo_enable_reg;
    assign cfg.line_capacity = line_capacity_reg;
    assign in_ready          = free;
    assign in_xfer           = in_valid && in_ready;
    assign load              = in_xfer && (bundle.count != 2'd0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg   <= 1'b1;
            line_capacity_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lee_pkg::CFG_ECHO_ENABLE:   echo_enable_reg   <= cfg_data[0];
                lee_pkg::CFG_LINE_CAPACITY: line_capacity_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // line length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_count_reg <= 8'd0;
        end
        else if (in_xfer)
        begin
            length_count_reg <= length_next;
        end
    end

    // decode of the incoming character
    lee_decode u_decode
    (
        .rx_char      (rx_char),
        .length_count (length_count_reg),
        .cfg          (cfg),
        .bundle       (bundle),
        .length_next  (length_next)
    );

    // result register and sequencing
    lee_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .bundle      (bundle),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .position    (position),
        .line_length (line_length),
        .last        (last)
    );

    // checks
    `LEE_ASSERT_NOW(a_ready_only_when_drained, in_ready,
        (!out_valid || (out_ready && last)), "input ready while results still pending")
    `LEE_ASSERT_NOW(a_done_is_last, (out_valid && (kind == lee_pkg::KIND_DONE)),
        (last && (data_byte == 8'd0) && (position == 8'd0)), "bad line complete result")
    `LEE_ASSERT_NOW(a_store_length, (out_valid && (kind == lee_pkg::KIND_STORE)),
        (line_length == (position + 8'd1)), "store position and length disagree")
    `LEE_ASSERT_NEXT(a_last_clears, (out_valid && out_ready && last && !in_valid),
        !out_valid, "result register not emptied after last transfer")

endmodule

// ----- dv/lee_checker.sv -----
`timescale 1ns / 1ps
// line editor checker: watches both channels, predicts results and compares them
module lee_checker
    import lee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic [7:0] rx_char,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic [7:0] position,
    input  logic [7:0] line_length,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    output int         error_count,
    output int         outstanding
);

    // one expected result, fields as the output ports carry them
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] line_length;
        logic       last;
    } editor_result_t;

    editor_result_t pending_results[$];
    editor_result_t want;

    // shadow of the editor state and its registers
    logic [7:0] line_len;
    logic       echo_on;
    logic [8:0] capacity;
    int         results_seen;

    task automatic report_mismatch(input string msg);
        $display("lee_checker: result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic add_result(input logic [1:0] k, input logic [7:0] d, input logic [7:0] p,
                              input logic [7:0] len, input logic fin);
        pending_results.push_back('{kind: k, data_byte: d, position: p,
                                    line_length: len, last: fin});
    endtask

    // work out the results of one received character and update the line length
    task automatic apply_char(input logic [7:0] ch);
        logic [8:0] usable;
        logic [7:0] done_len;
        usable = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
        if (ch == CHAR_CR || ch == CHAR_LF) begin
            done_len = line_len;
            if (echo_on) begin
                add_result(KIND_ECHO, CHAR_CR, 8'd0, 8'd0, 1'b0);
                add_result(KIND_ECHO, CHAR_LF, 8'd0, 8'd0, 1'b0);
            end
            add_result(KIND_DONE, 8'd0, 8'd0, done_len, 1'b1);
            line_len = 8'd0;
        end
        else if (ch == CHAR_BS || ch == CHAR_DEL) begin
            // erase on an empty line does nothing
            if (line_len != 8'd0) begin
                line_len = line_len - 8'd1;
                if (echo_on) begin
                    add_result(KIND_ECHO, CHAR_BS, 8'd0, line_len, 1'b0);
                    add_result(KIND_ECHO, CHAR_SPACE, 8'd0, line_len, 1'b0);
                    add_result(KIND_ECHO, CHAR_BS, 8'd0, line_len, 1'b1);
                end
            end
        end
        else if ({1'b0, line_len} + 9'd1 < usable) begin
            add_result(KIND_STORE, ch, line_len, line_len + 8'd1, !echo_on);
            line_len = line_len + 8'd1;
            if (echo_on)
                add_result(KIND_ECHO, ch, 8'd0, line_len, 1'b1);
        end
        // otherwise the buffer is full and the character is dropped
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            line_len     = 8'd0;
            echo_on      = 1'b1;
            capacity     = 9'd256;
            results_seen = 0;
            outstanding  = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_ECHO_ENABLE)
                    echo_on = cfg_data[0];
                else
                    capacity = cfg_data;
            end

            // output transfer against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                              kind, data_byte));
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
                    if (data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte got %02h want %02h",
                                                  data_byte, want.data_byte));
                    if (position !== want.position)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  position, want.position));
                    if (line_length !== want.line_length)
                        report_mismatch($sformatf("line_length got %0d want %0d",
                                                  line_length, want.line_length));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %b want %b", last, want.last));
                end
                results_seen++;
            end

            // input transfer
            if (in_valid && in_ready)
                apply_char(rx_char);

            outstanding = pending_results.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, character stimulus and verdict for the line editor
module tb_top;
    import lee_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 48;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [8:0] cfg_data;
    logic [7:0] rx_char;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [7:0] line_length;
    logic       last;
    logic       out_valid;
    logic       out_ready;

    int error_count;
    int outstanding;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit hold_armed  = 1'b0;
    bit hold_done   = 1'b0;

    // control characters and byte extremes on a fresh line
    logic [7:0] opening_chars[$] = '{CHAR_BS, CHAR_DEL, CHAR_CR, CHAR_LF, 8'h00, 8'hFF,
                                     8'h80, 8'h7E, CHAR_SPACE, 8'h41, CHAR_BS, CHAR_DEL,
                                     CHAR_DEL, CHAR_BS, 8'h55, 8'hAA, CHAR_CR, 8'h31,
                                     CHAR_LF};
    // a short buffer filling up, then an erase making room again
    logic [7:0] full_line_chars[$] = '{8'h61, 8'h62, 8'h63, CHAR_BS, 8'h65, CHAR_CR};

    line_editor_echo dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_char     (rx_char),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .position    (position),
        .line_length (line_length),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    lee_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_char     (rx_char),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .position    (position),
        .line_length (line_length),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: short random stalls, one long hold-off when armed
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 12)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one character transfer, entered and left at a falling edge
    task automatic send_char(input logic [7:0] ch);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_char  <= ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // both registers, written back to back while the editor is idle
    task automatic write_cfg(input logic echo, input logic [8:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ECHO_ENABLE;
        cfg_data  <= {8'd0, echo};
        @(negedge clk);
        cfg_index <= CFG_LINE_CAPACITY;
        cfg_data  <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for every expected result, then let a dropped character finish
    task automatic settle();
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // pick a character: line ends, erases, any byte, or printable text
    function automatic logic [7:0] pick_char(input int end_pct, input int erase_pct,
                                             input int noise_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < end_pct)
            return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
        if (roll < end_pct + erase_pct)
            return $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL;
        if (roll < end_pct + erase_pct + noise_pct)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    task automatic run_phase(input int count, input int end_pct, input int erase_pct,
                             input int noise_pct);
        repeat (count) send_char(pick_char(end_pct, erase_pct, noise_pct));
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ECHO_ENABLE;
        cfg_data  = 9'd0;
        rx_char   = 8'd0;
        in_valid  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, then a tiny buffer with echo off
        foreach (opening_chars[i]) send_char(opening_chars[i]);
        in_valid <= 1'b0;
        settle();
        write_cfg(1'b0, 9'd3);
        foreach (full_line_chars[i]) send_char(full_line_chars[i]);
        in_valid <= 1'b0;
        settle();

        // no room at all
        write_cfg(1'b0, 9'd0);
        run_phase(15, 10, 15, 30);
        settle();
        write_cfg(1'b1, 9'd1);
        run_phase(15, 10, 15, 30);
        settle();

        // one slot
        write_cfg(1'b1, 9'd2);
        run_phase(25, 12, 15, 20);
        settle();

        // short lines hitting the full buffer often
        write_cfg(1'b0, 9'd6);
        run_phase(30, 8, 12, 20);
        settle();

        // one long line past the top of the length range
        write_cfg(1'b1, 9'd511);
        run_phase(259, 0, 0, 0);
        send_char(CHAR_CR);
        in_valid <= 1'b0;
        settle();

        // full-size buffer with a long receiver hold-off
        write_cfg(1'b1, 9'd256);
        hold_armed <= 1'b1;
        run_phase(40, 6, 12, 20);
        settle();

        write_cfg(1'b1, 9'd255);
        run_phase(20, 6, 12, 40);
        settle();

        // closing stretch without idling
        write_cfg(1'b0, 9'd9);
        calm = 1'b1;
        run_phase(40, 8, 12, 30);
        settle();

        if (error_count == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- line_editor_echo.f -----
+incdir+sv
sv/lee_pkg.sv
sv/lee_decode.sv
sv/lee_emit.sv
sv/line_editor_echo.sv
dv/lee_checker.sv
dv/tb_top.sv
